>>> rtl/core/scanline_row_delta_compressor_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the scanline row-delta compressor checkers
// ---------------------------------------------------------------------------
`ifndef SCANLINE_ROW_DELTA_COMPRESSOR_MACROS_SVH
`define SCANLINE_ROW_DELTA_COMPRESSOR_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define SRDC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check, but also active while reset is asserted.
`define SRDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/srdc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srdc_pkg
// Shared constants and types of the scanline row-delta compressor.
// ---------------------------------------------------------------------------
package srdc_pkg;

    localparam int MAX_ROW_BYTES = 256;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W         = 9;
    localparam int GROUP_SIZE    = 8;
    localparam int SLOT_W        = $clog2(GROUP_SIZE);
    localparam int BYTE_W        = 8;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [LEN_W-1:0]  ROW_BYTES_RESET = LEN_W'(2);
    localparam logic [BYTE_W-1:0] FLAG_MSB        = 8'h80;
    localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(GROUP_SIZE - 1);

    // register index, taken from paddr[2]
    localparam logic REG_ROW_BYTES = 1'b0;

    // one finished group handed to the output stage
    typedef struct packed {
        logic [BYTE_W-1:0]                  flags;
        logic [GROUP_SIZE-1:0][BYTE_W-1:0]  bytes;
    } group_t;

endpackage

>>> rtl/core/srdc_emit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srdc_emit
// Output stage: sends the flag word of a group, then its changed bytes.
// ---------------------------------------------------------------------------
module srdc_emit
    import srdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_valid,
    input  group_t             load_group,
    output logic               load_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic               m_tuser,   // [0] is_flag
    output logic               m_tlast
);

    logic                              valid_reg;
    logic                              flag_pend_reg;
    logic [BYTE_W-1:0]                 flag_reg;
    logic [BYTE_W-1:0]                 mask_reg;
    logic [GROUP_SIZE-1:0][BYTE_W-1:0] data_reg;

    logic              valid_next;
    logic              flag_pend_next;
    logic [BYTE_W-1:0] mask_next;
    logic [SLOT_W-1:0] sel;
    logic [BYTE_W-1:0] mask_rest;
    logic              xfer;

    // lowest pending slot: slot k owns flag bit 7-k
    always_comb begin
        sel = '0;
        for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
            if (mask_reg[GROUP_SIZE-1-k]) begin
                sel = SLOT_W'(k);
            end
        end
    end

    assign mask_rest = mask_reg & ~(FLAG_MSB >> sel);

    assign m_tvalid = valid_reg;
    assign m_tdata  = flag_pend_reg ? flag_reg : data_reg[sel];
    assign m_tuser  = flag_pend_reg;
    assign m_tlast  = flag_pend_reg ? (mask_reg == '0) : (mask_rest == '0);

    assign xfer       = valid_reg && m_tready;
    assign load_ready = !valid_reg || (xfer && m_tlast);

    always_comb begin
        valid_next     = valid_reg;
        flag_pend_next = flag_pend_reg;
        mask_next      = mask_reg;
        if (load_valid && load_ready) begin
            valid_next     = 1'b1;
            flag_pend_next = 1'b1;
            mask_next      = load_group.flags;
        end else if (xfer) begin
            if (flag_pend_reg) begin
                flag_pend_next = 1'b0;
            end else begin
                mask_next = mask_rest;
            end
            if (m_tlast) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            flag_pend_reg <= 1'b0;
            mask_reg      <= '0;
        end else begin
            valid_reg     <= valid_next;
            flag_pend_reg <= flag_pend_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_valid && load_ready) begin
            flag_reg <= load_group.flags;
            data_reg <= load_group.bytes;
        end
    end

endmodule

>>> rtl/core/scanline_row_delta_compressor.sv
`timescale 1ns / 1ps
// A closing word is registered in the compare stage; the output stage then shows its flag word.
// Throughput: one input word per cycle while the output stage can take a closing group; that group
//   sends 1 + (changed bytes) words on the single output port, one per cycle while m_tready is high.
// Reset: synchronous, active low; clears column, flags and pipeline valids, sets the first-row mark,
//   row_bytes returns to 2. Previous-row memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
// scanline_row_delta_compressor
// Compresses bitmap rows against the previous row in groups of eight bytes.
// ---------------------------------------------------------------------------
module scanline_row_delta_compressor
    import srdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] pixel_byte
    input  logic               s_tuser,   // [0] start_of_image
    // compressed stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic               m_tuser,   // [0] is_flag
    output logic               m_tlast
);

    // configuration register
    logic [LEN_W-1:0] row_bytes_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= ROW_BYTES_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROW_BYTES) begin
            row_bytes_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ROW_BYTES) ? PDATA_W'(row_bytes_reg) : '0;

    // row position, tracked at acceptance
    logic [COL_W-1:0] column_reg;
    logic             first_row_reg;
    logic [COL_W-1:0] column_next;
    logic             first_row_next;
    logic [LEN_W-1:0] row_len;
    logic [COL_W-1:0] col;
    logic             first;
    logic             row_end;
    logic             accept;

    always_comb begin
        priority if (row_bytes_reg == '0) begin
            row_len = LEN_W'(1);
        end else if (row_bytes_reg > LEN_W'(MAX_ROW_BYTES)) begin
            row_len = LEN_W'(MAX_ROW_BYTES);
        end else begin
            row_len = row_bytes_reg;
        end
    end

    assign accept  = s_tvalid && s_tready;
    assign col     = s_tuser ? '0 : column_reg;
    assign first   = s_tuser ? 1'b1 : first_row_reg;
    assign row_end = (LEN_W'(col) + LEN_W'(1)) >= row_len;

    assign column_next    = row_end ? '0 : col + COL_W'(1);
    assign first_row_next = row_end ? 1'b0 : first;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
        end else if (accept) begin
            column_reg    <= column_next;
            first_row_reg <= first_row_next;
        end
    end

    // previous row: read the old byte and store the new one at the same edge
    logic [BYTE_W-1:0] prev_mem [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] prev_rd_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_rd_reg   <= prev_mem[col];
            prev_mem[col] <= s_tdata;
        end
    end

    // compare stage
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic              s1_end_reg;
    logic              s1_first_reg;
    logic              s1_sof_reg;

    logic [BYTE_W-1:0]                 change_flags_reg;
    logic [GROUP_SIZE-1:0][BYTE_W-1:0] group_reg;

    logic [BYTE_W-1:0]                 change_flags_next;
    logic [BYTE_W-1:0]                 flags_base;
    logic [BYTE_W-1:0]                 flags_new;
    logic [GROUP_SIZE-1:0][BYTE_W-1:0] group_next;
    logic                              changed;
    logic                              emit;
    logic                              s1_fire;
    logic                              load_ready;
    group_t                            load_group;

    always_comb begin
        // a new image drops any group in progress
        flags_base = s1_sof_reg ? '0 : change_flags_reg;
        changed    = s1_first_reg || (prev_rd_reg != s1_byte_reg);
        flags_new  = flags_base | (changed ? (FLAG_MSB >> s1_slot_reg) : '0);
        group_next = group_reg;
        group_next[s1_slot_reg] = s1_byte_reg;
    end

    assign emit              = (s1_slot_reg == LAST_SLOT) || s1_end_reg;
    assign s1_fire           = s1_valid_reg && (!emit || load_ready);
    assign change_flags_next = emit ? '0 : flags_new;
    assign s_tready          = !s1_valid_reg || s1_fire;

    assign load_group.flags = flags_new;
    assign load_group.bytes = group_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            change_flags_reg <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                change_flags_reg <= change_flags_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_byte_reg  <= s_tdata;
            s1_slot_reg  <= col[SLOT_W-1:0];
            s1_end_reg   <= row_end;
            s1_first_reg <= first;
            s1_sof_reg   <= s_tuser;
        end
        if (s1_fire) begin
            group_reg <= group_next;
        end
    end

    srdc_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (s1_valid_reg && emit),
        .load_group (load_group),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/core/srdc_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// srdc_check
// Port-level checks of the compressed stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "scanline_row_delta_compressor_macros.svh"

module srdc_check
    import srdc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              pready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    // stalled word stays offered and unchanged
    `SRDC_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")
    `SRDC_ASSERT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "m_t* changed while stalled")

    // a flag word with no bits set has no data behind it
    `SRDC_ASSERT(a_empty_flag_last, aclk, aresetn, m_tvalid && m_tuser && m_tdata == '0 |-> m_tlast, "empty flag word not marked last")

    // a burst runs without gaps, and only its first word is a flag
    `SRDC_ASSERT(a_burst_cont, aclk, aresetn, m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser, "burst broken or second flag word")

    `SRDC_ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready low")

endmodule

bind scanline_row_delta_compressor srdc_check u_srdc_check (.*);
